### rtl/core/pli_pkg.sv
package pli_pkg;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // read-out tree: fan-in per node as a shift amount
    localparam int TREE_SHIFT = 4;
    localparam int TREE_FANIN = 1 << TREE_SHIFT;

    // per-cell command, shared by every cell of the row
    typedef struct packed {
        logic ins_en;   // insert: cells above pos take lower neighbor
        logic rem_en;   // remove: cells at/above pos take upper neighbor
        logic rd_en;    // read: cell at pos drives its word to the tree
    } cell_ctrl_t;

    // nodes in tree level lvl over n leaves
    function automatic int lvl_size(input int n, input int lvl);
        int s;
        s = n;
        for (int i = 0; i < lvl; i++) begin
            s = (s + TREE_FANIN - 1) >> TREE_SHIFT;
        end
        return s;
    endfunction

    // reduction levels above the leaves
    function automatic int num_levels(input int n);
        int s;
        int l;
        s = n;
        l = 0;
        for (int i = 0; i < 32; i++) begin
            if (s > 1) begin
                s = (s + TREE_FANIN - 1) >> TREE_SHIFT;
                l = l + 1;
            end
        end
        return l;
    endfunction

    // first flat node index of level lvl
    function automatic int lvl_off(input int n, input int lvl);
        int o;
        o = 0;
        for (int i = 0; i < lvl; i++) begin
            o = o + lvl_size(n, i);
        end
        return o;
    endfunction

endpackage

### rtl/core/pli_cell.sv
module pli_cell #(
    parameter int PW  = 9,
    parameter int DW  = 32,
    parameter int POS = 0
) (
    input  logic                aclk,
    input  pli_pkg::cell_ctrl_t ctrl,
    input  logic [PW-1:0]       pos,
    input  logic [DW-1:0]       value,
    input  logic [DW-1:0]       prev_data,
    input  logic [DW-1:0]       next_data,
    output logic [DW-1:0]       data_out,
    output logic [DW-1:0]       rd_out
);

    localparam logic [PW-1:0] MY_POS = PW'(POS);

    logic [DW-1:0] data_reg;
    logic [DW-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.ins_en) begin
            if (MY_POS > pos) begin
                data_next = prev_data;
            end else if (MY_POS == pos) begin
                data_next = value;
            end
        end else if (ctrl.rem_en) begin
            if (MY_POS >= pos) begin
                data_next = next_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;
    assign rd_out   = (ctrl.rd_en && (MY_POS == pos)) ? data_reg : '0;

endmodule

### rtl/core/pli_or_tree.sv
module pli_or_tree #(
    parameter int N = 256,
    parameter int W = 32
) (
    input  logic                aclk,
    input  logic                leaf_en,
    input  logic [N-1:0][W-1:0] leaf_in,
    output logic [W-1:0]        root
);

    localparam int L = pli_pkg::num_levels(N);
    localparam int T = pli_pkg::lvl_off(N, L + 1);

    logic [W-1:0] node_reg [T];
    wire  [W-1:0] node_or  [T-N];

    for (genvar k = 1; k <= L; k++) begin : g_lvl
        localparam int SZ   = pli_pkg::lvl_size(N, k);
        localparam int PSZ  = pli_pkg::lvl_size(N, k - 1);
        localparam int OFF  = pli_pkg::lvl_off(N, k);
        localparam int POFF = pli_pkg::lvl_off(N, k - 1);
        for (genvar j = 0; j < SZ; j++) begin : g_node
            localparam int CB = POFF + j * pli_pkg::TREE_FANIN;
            localparam int CN = (PSZ - j * pli_pkg::TREE_FANIN > pli_pkg::TREE_FANIN) ?
                                pli_pkg::TREE_FANIN : PSZ - j * pli_pkg::TREE_FANIN;
            logic [W-1:0] acc;
            always_comb begin
                acc = '0;
                for (int c = 0; c < CN; c++) begin
                    acc = acc | node_reg[CB + c];
                end
            end
            assign node_or[OFF + j - N] = acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (leaf_en) begin
            for (int i = 0; i < N; i++) begin
                node_reg[i] <= leaf_in[i];
            end
        end
        for (int n = N; n < T; n++) begin
            node_reg[n] <= node_or[n - N];
        end
    end

    assign root = node_reg[T-1];

endmodule

### rtl/core/positional_list_insert_remove_core.sv
// Channel  Dir  Ports                        Word layout (low bit first)
// s_       in   s_tvalid s_tready s_tdata    op[1:0] index[10:2] value[42:11], pad to 48
// m_       out  m_tvalid m_tready m_tdata    read_value[31:0] count[40:32] status[42:41]
//
// One operation at a time. Insert/remove/read are decided by every cell of the
// row in the accept cycle, so the list is updated at the accept edge. A read
// word then climbs a registered 16-way OR tree: L = ceil(log16(DEPTH)) levels
// (2 at DEPTH=256), and s_tready returns together with m_tvalid, so the next
// word is accepted only once the last one reaches the output register. A stalled
// m_ side holds the finished word in the output register; the next word is
// accepted meanwhile and waits at the tree root. Reset (aresetn low, sync)
// empties the list; entries themselves are not cleared.
module positional_list_insert_remove_core #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // op[1:0], index[10:2], value[42:11]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // read_value[31:0], count[40:32], status[42:41]
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PW  = (CW > 9) ? CW : 9;
    localparam int L   = pli_pkg::num_levels(DEPTH);
    localparam int WCW = $clog2(L + 1);

    localparam logic STATE_IDLE = 1'b0;
    localparam logic STATE_WAIT = 1'b1;

    // input word fields
    logic [1:0]  s_op;
    logic [8:0]  s_index;
    logic [31:0] s_value;

    assign s_op    = s_tdata[1:0];
    assign s_index = s_tdata[10:2];
    assign s_value = s_tdata[42:11];

    logic            state_reg;
    logic            state_next;
    logic [WCW-1:0]  wait_reg;
    logic [WCW-1:0]  wait_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [1:0]      status_reg;
    logic [1:0]      status_next;
    logic [8:0]      cnt_out_reg;
    logic            m_tvalid_reg;
    logic            m_tvalid_next;
    logic [47:0]     m_tdata_reg;

    logic            accept;
    logic [PW-1:0]   idx_w;
    logic [PW-1:0]   cnt_w;
    logic [PW-1:0]   pos;
    logic            full;
    logic            in_range;
    logic            ins_ok;
    logic            rem_ok;
    logic            rd_ok;
    logic            out_load;
    pli_pkg::cell_ctrl_t ctrl;

    logic [DATA_WIDTH-1:0]            value_dw;
    logic [DATA_WIDTH-1:0]            cell_data [DEPTH];
    logic [DEPTH-1:0][DATA_WIDTH-1:0] rd_leaf;
    logic [DATA_WIDTH-1:0]            root;

    assign s_tready = (state_reg == STATE_IDLE);
    assign accept   = s_tvalid && s_tready;

    // position: index clamped to count (append for insert; remove/read in
    // range leave it as is)
    assign idx_w    = PW'(s_index);
    assign cnt_w    = PW'(count_reg);
    assign pos      = (idx_w >= cnt_w) ? cnt_w : idx_w;
    assign full     = (count_reg == CW'(DEPTH));
    assign in_range = (idx_w < cnt_w);
    assign ins_ok   = (s_op == pli_pkg::OP_INSERT) && !full;
    assign rem_ok   = (s_op == pli_pkg::OP_REMOVE) && in_range;
    assign rd_ok    = (s_op == pli_pkg::OP_READ) && in_range;

    assign ctrl.ins_en = accept && ins_ok;
    assign ctrl.rem_en = accept && rem_ok;
    assign ctrl.rd_en  = accept && rd_ok;

    assign value_dw = DATA_WIDTH'(s_value);

    // row of cells, each one list position
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] prev_d;
        logic [DATA_WIDTH-1:0] next_d;
        if (i == 0) begin : g_first
            assign prev_d = '0;
        end else begin : g_mid_lo
            assign prev_d = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign next_d = '0;
        end else begin : g_mid_hi
            assign next_d = cell_data[i+1];
        end
        pli_cell #(
            .PW  (PW),
            .DW  (DATA_WIDTH),
            .POS (i)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .pos       (pos),
            .value     (value_dw),
            .prev_data (prev_d),
            .next_data (next_d),
            .data_out  (cell_data[i]),
            .rd_out    (rd_leaf[i])
        );
    end

    // read word: zero unless a read hit, so the root is read_value as is
    pli_or_tree #(
        .N (DEPTH),
        .W (DATA_WIDTH)
    ) u_tree (
        .aclk    (aclk),
        .leaf_en (accept),
        .leaf_in (rd_leaf),
        .root    (root)
    );

    always_comb begin
        count_next = count_reg;
        if (ctrl.ins_en) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.rem_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb begin
        if (s_op == pli_pkg::OP_INSERT) begin
            status_next = full ? pli_pkg::STAT_FULL : pli_pkg::STAT_OK;
        end else if (rem_ok || rd_ok) begin
            status_next = pli_pkg::STAT_OK;
        end else begin
            status_next = pli_pkg::STAT_RANGE;
        end
    end

    // result leaves the tree once all levels have settled and m_ is free
    assign out_load = (state_reg == STATE_WAIT) && (wait_reg == '0) &&
                      (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        wait_next     = wait_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            STATE_IDLE: begin
                if (accept) begin
                    state_next = STATE_WAIT;
                    wait_next  = WCW'(L);
                end
            end
            STATE_WAIT: begin
                if (wait_reg != '0) begin
                    wait_next = wait_reg - 1'b1;
                end else if (out_load) begin
                    state_next    = STATE_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= STATE_IDLE;
            wait_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wait_reg     <= wait_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg  <= status_next;
            cnt_out_reg <= 9'(PW'(count_next));
        end
        if (out_load) begin
            m_tdata_reg <= {5'd0, status_reg, cnt_out_reg, 32'(root)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above capacity");

    a_insert_grows : assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.ins_en |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not raise count");

    a_remove_shrinks : assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.rem_en |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("remove did not lower count");

    a_hold_result : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");
`endif

endmodule
